FILE: design/run_length_packet_decoder_unit_defines.svh
// assertion macros shared by the run-length packet decoder modules
`ifndef RUN_LENGTH_PACKET_DECODER_UNIT_DEFINES_SVH
`define RUN_LENGTH_PACKET_DECODER_UNIT_DEFINES_SVH

`ifndef SYNTH

`define RLPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("rlpd assertion failed");

`define RLPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("rlpd assertion failed");

`else

`define RLPD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)

`define RLPD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

FILE: design/rlpd_pkg.sv
// types and constants of the run-length packet decoder
package rlpd_pkg;

	localparam logic [31:0] MAGIC_WORD = 32'h21494D46;
	localparam int RUN_FLAG_BIT = 7;

	localparam logic KIND_DATA = 1'b0;
	localparam logic KIND_STATUS = 1'b1;

	localparam logic [1:0] STATUS_OK = 2'd0;
	localparam logic [1:0] STATUS_BAD_MAGIC = 2'd1;
	localparam logic [1:0] STATUS_SIZE_MISMATCH = 2'd2;
	localparam logic [1:0] STATUS_TRUNCATED = 2'd3;

	typedef struct packed {
		logic kind;
		logic [7:0] out_byte;
		logic [7:0] repeat_count;
		logic [1:0] status;
		logic last;
	} rlpd_res_t;

	// up to two results per input byte, a before b
	typedef struct packed {
		logic [1:0] cnt;
		rlpd_res_t a;
		rlpd_res_t b;
	} rlpd_push_t;

	function automatic logic [7:0] magic_byte(input logic [1:0] idx);
		magic_byte = MAGIC_WORD[{idx, 3'b000} +: 8];
	endfunction

endpackage

FILE: design/rlpd_decode.sv
// decode state and per-byte result generation of the run-length packet decoder
`include "run_length_packet_decoder_unit_defines.svh"

module rlpd_decode (
	input logic clk,
	input logic arst_n,
	input logic adv,
	input logic [7:0] in_byte,
	input logic stream_end,
	output rlpd_pkg::rlpd_push_t push
);
	import rlpd_pkg::*;

	typedef enum logic [2:0] {
		PH_HEADER,
		PH_PKT,
		PH_REPEAT,
		PH_LITERAL,
		PH_DRAIN
	} phase_t;

	phase_t phase_q, phase_d;
	logic [3:0] hdr_idx_q, hdr_idx_d;
	logic [31:0] packets_q, packets_d;
	logic [63:0] expected_q, expected_d;
	logic [63:0] produced_q, produced_d;
	logic [7:0] lit_q, lit_d;
	logic [7:0] repeat_q, repeat_d;
	logic magic_bad_q, magic_bad_d;

	logic [7:0] add_amt;
	logic [64:0] sum_wide;
	logic [63:0] sum_sat;
	logic [7:0] pkt_cnt;
	logic [7:0] lit_dec;
	logic pkt_done;
	logic finished;
	logic restart;
	logic data_valid;
	logic [7:0] data_cnt;
	logic stat_valid;
	logic [1:0] st;
	logic [1:0] size_st;

	always_comb begin
		unique case (phase_q)
			PH_REPEAT: add_amt = repeat_q;
			PH_LITERAL: add_amt = 8'd1;
			default: add_amt = 8'd0;
		endcase
	end

	// saturating output counter
	assign sum_wide = {1'b0, produced_q} + {57'b0, add_amt};
	assign sum_sat = sum_wide[64] ? {64{1'b1}} : sum_wide[63:0];
	assign pkt_cnt = {1'b0, in_byte[6:0]} + 8'd1;
	assign lit_dec = (lit_q == 8'd0) ? 8'd0 : lit_q - 8'd1;

	always_comb begin
		phase_d = phase_q;
		hdr_idx_d = hdr_idx_q;
		packets_d = packets_q;
		expected_d = expected_q;
		produced_d = produced_q;
		lit_d = lit_q;
		repeat_d = repeat_q;
		magic_bad_d = magic_bad_q;
		pkt_done = 1'b0;
		finished = 1'b0;
		restart = 1'b0;
		data_valid = 1'b0;
		data_cnt = 8'd1;
		stat_valid = 1'b0;
		st = STATUS_OK;
		size_st = STATUS_OK;
		unique case (phase_q)
			PH_HEADER: begin
				if (hdr_idx_q[3:2] == 2'b00) begin
					magic_bad_d = magic_bad_q | (in_byte != magic_byte(hdr_idx_q[1:0]));
					if (hdr_idx_q[1:0] == 2'd3 && magic_bad_d) begin
						finished = 1'b1;
						st = STATUS_BAD_MAGIC;
					end
				end else if (!hdr_idx_q[3]) begin
					packets_d = packets_q | ({24'b0, in_byte} << {hdr_idx_q[1:0], 3'b000});
				end else begin
					expected_d = expected_q | ({56'b0, in_byte} << {hdr_idx_q[2:0], 3'b000});
				end
				size_st = (sum_sat == expected_d) ? STATUS_OK : STATUS_SIZE_MISMATCH;
				if (!finished) begin
					if (hdr_idx_q == 4'd15) begin
						if (packets_d == 32'd0) begin
							finished = 1'b1;
							st = size_st;
						end else begin
							phase_d = PH_PKT;
						end
					end else begin
						hdr_idx_d = hdr_idx_q + 4'd1;
					end
				end
			end
			PH_PKT: begin
				if (in_byte[RUN_FLAG_BIT]) begin
					repeat_d = pkt_cnt;
					phase_d = PH_REPEAT;
				end else begin
					lit_d = pkt_cnt;
					phase_d = PH_LITERAL;
				end
			end
			PH_REPEAT: begin
				data_valid = 1'b1;
				data_cnt = repeat_q;
				produced_d = sum_sat;
				repeat_d = 8'd0;
				pkt_done = 1'b1;
			end
			PH_LITERAL: begin
				data_valid = 1'b1;
				produced_d = sum_sat;
				lit_d = lit_dec;
				pkt_done = (lit_dec == 8'd0);
			end
			PH_DRAIN: begin
			end
			default: begin
			end
		endcase

		if (pkt_done) begin
			packets_d = packets_q - 32'd1;
			size_st = (sum_sat == expected_q) ? STATUS_OK : STATUS_SIZE_MISMATCH;
			if (packets_d == 32'd0) begin
				finished = 1'b1;
				st = size_st;
			end else begin
				phase_d = PH_PKT;
			end
		end

		if (finished) begin
			stat_valid = 1'b1;
			if (stream_end) begin
				restart = 1'b1;
			end else begin
				phase_d = PH_DRAIN;
			end
		end else if (stream_end) begin
			// early end of stream, trailing bytes after a status are silent
			stat_valid = (phase_q != PH_DRAIN);
			st = STATUS_TRUNCATED;
			restart = 1'b1;
		end
	end

	always_comb begin
		push.cnt = 2'd0;
		push.a.kind = KIND_DATA;
		push.a.out_byte = in_byte;
		push.a.repeat_count = data_cnt;
		push.a.status = STATUS_OK;
		push.a.last = !stat_valid;
		push.b.kind = KIND_STATUS;
		push.b.out_byte = 8'd0;
		push.b.repeat_count = 8'd0;
		push.b.status = st;
		push.b.last = 1'b1;
		if (!data_valid) begin
			push.a = push.b;
		end
		if (adv) begin
			push.cnt = {1'b0, data_valid} + {1'b0, stat_valid};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hdr_idx_q <= 4'd0;
			packets_q <= 32'd0;
			expected_q <= 64'd0;
			produced_q <= 64'd0;
			lit_q <= 8'd0;
			repeat_q <= 8'd0;
			magic_bad_q <= 1'b0;
		end else if (adv) begin
			if (restart) begin
				phase_q <= PH_HEADER;
				hdr_idx_q <= 4'd0;
				packets_q <= 32'd0;
				expected_q <= 64'd0;
				produced_q <= 64'd0;
				lit_q <= 8'd0;
				repeat_q <= 8'd0;
				magic_bad_q <= 1'b0;
			end else begin
				phase_q <= phase_d;
				hdr_idx_q <= hdr_idx_d;
				packets_q <= packets_d;
				expected_q <= expected_d;
				produced_q <= produced_d;
				lit_q <= lit_d;
				repeat_q <= repeat_d;
				magic_bad_q <= magic_bad_d;
			end
		end
	end

	`RLPD_ASSERT_IMP(a_status_is_last, clk, arst_n, push.cnt == 2'd2, push.a.kind == KIND_DATA && push.b.kind == KIND_STATUS)
	`RLPD_ASSERT_IMP(a_last_flag, clk, arst_n, push.cnt != 2'd0, push.a.last == (push.cnt == 2'd1))
	`RLPD_ASSERT_NXT(a_drain_after_status, clk, arst_n, adv && stat_valid && !stream_end, phase_q == PH_DRAIN)

endmodule

FILE: design/rlpd_out_fifo.sv
// result queue that takes up to two results and gives one per cycle while pop is high
`include "run_length_packet_decoder_unit_defines.svh"

module rlpd_out_fifo #(
	parameter int OutDepth = 4
) (
	input logic clk,
	input logic arst_n,
	input rlpd_pkg::rlpd_push_t push,
	output logic space,
	input logic pop,
	output logic out_valid,
	output rlpd_pkg::rlpd_res_t head
);
	import rlpd_pkg::*;

	localparam int PtrW = (OutDepth > 1) ? $clog2(OutDepth) : 1;
	localparam int CntW = $clog2(OutDepth + 1);

	rlpd_res_t mem_q [OutDepth];
	logic [PtrW-1:0] wr_ptr_q;
	logic [PtrW-1:0] rd_ptr_q;
	logic [CntW-1:0] count_q;
	logic [PtrW-1:0] wr_ptr_inc;
	logic pop_fire;

	function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
		ptr_inc = (p == PtrW'(OutDepth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign wr_ptr_inc = ptr_inc(wr_ptr_q);
	assign pop_fire = pop && out_valid;
	assign out_valid = (count_q != '0);
	assign head = mem_q[rd_ptr_q];
	// room for the worst case of two results from one byte
	assign space = (count_q <= CntW'(OutDepth - 2));

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_ptr_q] <= push.a;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_ptr_inc] <= push.b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push.cnt == 2'd1) begin
				wr_ptr_q <= wr_ptr_inc;
			end else if (push.cnt == 2'd2) begin
				wr_ptr_q <= ptr_inc(wr_ptr_inc);
			end
			if (pop_fire) begin
				rd_ptr_q <= ptr_inc(rd_ptr_q);
			end
			count_q <= CntW'(count_q + CntW'(push.cnt) - CntW'(pop_fire));
		end
	end

	`RLPD_ASSERT_IMP(a_push_has_room, clk, arst_n, push.cnt != 2'd0, count_q <= CntW'(OutDepth - 2))
	`RLPD_ASSERT_NXT(a_empty_after_last_pop, clk, arst_n, count_q == CntW'(1) && pop_fire && push.cnt == 2'd0, !out_valid)

endmodule

FILE: design/run_length_packet_decoder_unit.sv
// run-length packet decoder: a compressed byte stream in, decoded words out
// input channel: in_valid/in_ready carry one compressed byte (in_byte) and
// stream_end, which marks the final byte of a stream.
// output channel: out_valid/out_ready carry one result word: a data word
// (kind 0, out_byte written repeat_count times) or a status word (kind 1).
// last_of_item flags the final word caused by one input byte.
// a byte accepted on the input is held in the input register (byte_s1),
// goes through the decode logic and is written into the queue once the
// queue has room; its words then reach the output in order.
// one byte is accepted per cycle while each byte yields at most one word
// and the receiver takes every word; the data and status words of one byte
// leave one at a time through the single output port of the result queue.
// the queue holds OutDepth words; a held byte is decoded only while at least
// two entries are free, so a stalled receiver fills the queue and then holds
// in_ready low without losing or reordering words.
// reset clears the decode state to the start of a header and empties the
// queue; after a byte with stream_end the next byte begins a new stream.
module run_length_packet_decoder_unit #(
	parameter int OutDepth = 4
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [7:0] in_byte,
	input logic stream_end,
	output logic out_valid,
	input logic out_ready,
	output logic kind,
	output logic [7:0] out_byte,
	output logic [7:0] repeat_count,
	output logic [1:0] status,
	output logic last_of_item
);
	import rlpd_pkg::*;

	logic valid_s1;
	logic [7:0] byte_s1;
	logic end_s1;
	logic space;
	logic adv;
	rlpd_push_t push;
	rlpd_res_t head;

	assign adv = valid_s1 && space;
	assign in_ready = !valid_s1 || space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_valid && in_ready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			byte_s1 <= in_byte;
			end_s1 <= stream_end;
		end
	end

	rlpd_decode u_decode (
		.clk(clk),
		.arst_n(arst_n),
		.adv(adv),
		.in_byte(byte_s1),
		.stream_end(end_s1),
		.push(push)
	);

	rlpd_out_fifo #(
		.OutDepth(OutDepth)
	) u_out_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.space(space),
		.pop(out_ready),
		.out_valid(out_valid),
		.head(head)
	);

	assign kind = head.kind;
	assign out_byte = head.out_byte;
	assign repeat_count = head.repeat_count;
	assign status = head.status;
	assign last_of_item = head.last;

endmodule

FILE: test/run_length_packet_decoder_unit_test.sv
// self-checking testbench of the run-length packet decoder with random flow control
module run_length_packet_decoder_unit_test;
	import rlpd_pkg::*;

	localparam int STALL_LIMIT = 3000;
	localparam int LONG_HOLD = 400;
	localparam int BYTE_TARGET = 1900;

	typedef enum logic [2:0] {
		DEC_HDR,
		DEC_PKT,
		DEC_RUN,
		DEC_LIT,
		DEC_DRAIN
	} dec_phase_t;

	typedef struct packed {
		logic [7:0] b;
		logic fin;
	} comp_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [7:0] in_byte = '0;
	logic stream_end = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic kind;
	logic [7:0] out_byte;
	logic [7:0] repeat_count;
	logic [1:0] status;
	logic last_of_item;

	comp_byte_t pending_bytes[$];
	rlpd_res_t expected_words[$];

	// decoder state as the testbench sees it
	dec_phase_t ph = DEC_HDR;
	logic [3:0] hdr_idx = '0;
	logic [31:0] pkts_left = '0;
	logic [63:0] size_expected = '0;
	logic [63:0] size_made = '0;
	logic [7:0] lit_left = '0;
	logic [7:0] run_len = '0;
	logic magic_bad = 1'b0;

	int mismatches = 0;
	int bytes_in = 0;
	int streams_in = 0;
	int words_out = 0;
	int status_seen[4] = '{0, 0, 0, 0};
	int stuck_cycles = 0;
	int unsigned tx_gap = 0;
	int unsigned rx_gap = 0;
	logic tx_burst = 1'b0;
	logic rx_burst = 1'b0;

	run_length_packet_decoder_unit DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_byte(in_byte),
		.stream_end(stream_end),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.kind(kind),
		.out_byte(out_byte),
		.repeat_count(repeat_count),
		.status(status),
		.last_of_item(last_of_item)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	task automatic decoder_restart();
		ph = DEC_HDR;
		hdr_idx = '0;
		pkts_left = '0;
		size_expected = '0;
		size_made = '0;
		lit_left = '0;
		run_len = '0;
		magic_bad = 1'b0;
	endtask

	task automatic count_output(input logic [7:0] k);
		if (size_made > ~64'd0 - 64'(k)) begin
			size_made = ~64'd0;
		end else begin
			size_made = size_made + 64'(k);
		end
	endtask

	// works out the words that one accepted byte causes
	task automatic decode_byte(input logic [7:0] b, input logic fin);
		dec_phase_t was;
		logic done;
		logic pkt_done;
		logic [1:0] st;
		rlpd_res_t got[2];
		int n;
		was = ph;
		done = 1'b0;
		pkt_done = 1'b0;
		st = STATUS_OK;
		n = 0;
		case (ph)
			DEC_HDR: begin
				if (hdr_idx < 4) begin
					if (b != MAGIC_WORD[8 * hdr_idx +: 8]) magic_bad = 1'b1;
					if (hdr_idx == 3 && magic_bad) begin
						done = 1'b1;
						st = STATUS_BAD_MAGIC;
					end
				end else if (hdr_idx < 8) begin
					pkts_left[8 * (hdr_idx - 4) +: 8] = b;
				end else begin
					size_expected[8 * (hdr_idx - 8) +: 8] = b;
				end
				if (!done) begin
					if (hdr_idx == 15) begin
						if (pkts_left == 0) begin
							done = 1'b1;
							st = (size_made == size_expected) ? STATUS_OK : STATUS_SIZE_MISMATCH;
						end else begin
							ph = DEC_PKT;
						end
					end else begin
						hdr_idx = hdr_idx + 4'd1;
					end
				end
			end
			DEC_PKT: begin
				if (b[RUN_FLAG_BIT]) begin
					run_len = {1'b0, b[6:0]} + 8'd1;
					ph = DEC_RUN;
				end else begin
					lit_left = {1'b0, b[6:0]} + 8'd1;
					ph = DEC_LIT;
				end
			end
			DEC_RUN, DEC_LIT: begin
				if (ph == DEC_RUN) begin
					got[n] = '{kind: KIND_DATA, out_byte: b, repeat_count: run_len,
						status: STATUS_OK, last: 1'b0};
					n++;
					count_output(run_len);
					run_len = '0;
					pkt_done = 1'b1;
				end else begin
					got[n] = '{kind: KIND_DATA, out_byte: b, repeat_count: 8'd1,
						status: STATUS_OK, last: 1'b0};
					n++;
					count_output(8'd1);
					if (lit_left > 0) lit_left = lit_left - 8'd1;
					pkt_done = (lit_left == 0);
				end
				if (pkt_done) begin
					pkts_left = pkts_left - 32'd1;
					if (pkts_left == 0) begin
						done = 1'b1;
						st = (size_made == size_expected) ? STATUS_OK : STATUS_SIZE_MISMATCH;
					end else begin
						ph = DEC_PKT;
					end
				end
			end
			default: ;
		endcase
		if (done) begin
			got[n] = '{kind: KIND_STATUS, out_byte: 8'd0, repeat_count: 8'd0, status: st, last: 1'b0};
			n++;
			if (fin) decoder_restart();
			else ph = DEC_DRAIN;
		end else if (fin) begin
			if (was != DEC_DRAIN) begin
				got[n] = '{kind: KIND_STATUS, out_byte: 8'd0, repeat_count: 8'd0,
					status: STATUS_TRUNCATED, last: 1'b0};
				n++;
			end
			decoder_restart();
		end
		if (n > 0) got[n - 1].last = 1'b1;
		for (int i = 0; i < n; i++) expected_words.push_back(got[i]);
	endtask

	task automatic put_header(ref logic [7:0] s[$], input logic [31:0] magic,
		input logic [31:0] pkts, input logic [63:0] size);
		for (int i = 0; i < 4; i++) s.push_back(magic[8 * i +: 8]);
		for (int i = 0; i < 4; i++) s.push_back(pkts[8 * i +: 8]);
		for (int i = 0; i < 8; i++) s.push_back(size[8 * i +: 8]);
	endtask

	// end flag goes on the final byte of the stream
	task automatic queue_bytes(input logic [7:0] s[$]);
		foreach (s[i]) pending_bytes.push_back('{b: s[i], fin: (i == s.size() - 1)});
	endtask

	task automatic add_random_stream();
		logic [7:0] s[$];
		logic [7:0] body[$];
		logic [31:0] pkts;
		logic [31:0] magic;
		logic [63:0] total;
		logic [63:0] size;
		int unsigned pick;
		int unsigned len;
		int unsigned cut;
		pick = $urandom_range(0, 99);
		pkts = ($urandom_range(0, 19) == 0) ? 32'd0 : 32'($urandom_range(1, 6));
		total = '0;
		for (int p = 0; p < pkts; p++) begin
			len = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 127) : $urandom_range(0, 7);
			if ($urandom_range(0, 1) == 1) begin
				body.push_back(8'h80 | 8'(len));
				body.push_back(8'($urandom()));
			end else begin
				body.push_back(8'(len));
				repeat (len + 1) body.push_back(8'($urandom()));
			end
			total = total + 64'(len + 1);
		end
		magic = MAGIC_WORD;
		if (pick < 6) magic = magic ^ (32'd1 << $urandom_range(0, 31));
		size = total;
		if (pick >= 6 && pick < 16) begin
			size = ($urandom_range(0, 1) == 1) ? total + 64'd1 : {$urandom(), $urandom()};
		end
		put_header(s, magic, pkts, size);
		foreach (body[i]) s.push_back(body[i]);
		if (pick >= 90) begin
			// noise, with or without a good header in front
			s.delete();
			if ($urandom_range(0, 1) == 1) begin
				put_header(s, MAGIC_WORD, $urandom(), {$urandom(), $urandom()});
			end
			repeat ($urandom_range(1, 30)) s.push_back(8'($urandom()));
		end else if (pick >= 16 && pick < 28) begin
			cut = $urandom_range(1, s.size() - 1);
			while (s.size() > cut) void'(s.pop_back());
		end else if (pick >= 28 && pick < 38) begin
			repeat ($urandom_range(1, 4)) s.push_back(8'($urandom()));
		end
		queue_bytes(s);
	endtask

	function automatic int unsigned pick_gap(input logic burst);
		if (burst) return 0;
		return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 17) : $urandom_range(0, 2);
	endfunction

	always @(posedge clk or negedge arst_n) begin : feed
		comp_byte_t nxt;
		logic take;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_byte <= '0;
			stream_end <= 1'b0;
			tx_gap = 0;
			decoder_restart();
		end else begin
			take = in_valid && in_ready;
			if (take) begin
				decode_byte(in_byte, stream_end);
				bytes_in++;
				if (stream_end) streams_in++;
				if ($urandom_range(0, 49) == 0) tx_burst = ~tx_burst;
				tx_gap = pick_gap(tx_burst);
			end
			if (take || !in_valid) begin
				if (tx_gap > 0) begin
					tx_gap--;
					in_valid <= 1'b0;
				end else if (pending_bytes.size() > 0) begin
					nxt = pending_bytes.pop_front();
					in_valid <= 1'b1;
					in_byte <= nxt.b;
					stream_end <= nxt.fin;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : sink
		rlpd_res_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
			rx_gap = 0;
		end else begin
			if (out_valid && out_ready) begin
				words_out++;
				if (expected_words.size() == 0) begin
					$error("word with none expected: kind %0d out_byte %0h status %0d",
						kind, out_byte, status);
					mismatches++;
				end else begin
					want = expected_words.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, got %0d", want.kind, kind);
						mismatches++;
					end
					if (out_byte !== want.out_byte) begin
						$error("out_byte: expected %0h, got %0h", want.out_byte, out_byte);
						mismatches++;
					end
					if (repeat_count !== want.repeat_count) begin
						$error("repeat_count: expected %0d, got %0d", want.repeat_count,
							repeat_count);
						mismatches++;
					end
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						mismatches++;
					end
					if (last_of_item !== want.last) begin
						$error("last_of_item: expected %0d, got %0d", want.last, last_of_item);
						mismatches++;
					end
					if (want.kind == KIND_STATUS) status_seen[want.status]++;
				end
				if ($urandom_range(0, 49) == 0) rx_burst = ~rx_burst;
				rx_gap = pick_gap(rx_burst);
				// long hold-off so the result queue fills and input stalls
				if (words_out == 200 || words_out == 900) rx_gap = LONG_HOLD;
			end
			if (rx_gap > 0) begin
				rx_gap--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watchdog
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
			stuck_cycles = 0;
		end else if (stuck_cycles >= STALL_LIMIT) begin
			$display("run_length_packet_decoder_unit verification failed");
			$finish;
		end else begin
			stuck_cycles++;
		end
	end

	initial begin : stimulus
		logic [7:0] s[$];
		// bad magic on the last magic byte, rest of the header drains
		put_header(s, MAGIC_WORD ^ 32'h8000_0000, 32'd5, '0);
		queue_bytes(s);
		// no packets and zero size: ok on the last header byte
		s.delete();
		put_header(s, MAGIC_WORD, '0, '0);
		queue_bytes(s);
		// longest run and a one-byte literal against an all-ones size
		s.delete();
		put_header(s, MAGIC_WORD, 32'd2, '1);
		s.push_back(8'hFF);
		s.push_back(8'hFF);
		s.push_back(8'h00);
		s.push_back(8'h00);
		queue_bytes(s);
		// shortest run with matching size, then trailing bytes
		s.delete();
		put_header(s, MAGIC_WORD, 32'd1, 64'd1);
		s.push_back(8'h80);
		s.push_back(8'hA5);
		s.push_back(8'h5A);
		s.push_back(8'hFF);
		queue_bytes(s);
		// end flag in the middle of a literal packet
		s.delete();
		put_header(s, MAGIC_WORD, 32'd1, 64'd5);
		s.push_back(8'h04);
		s.push_back(8'h12);
		s.push_back(8'h34);
		queue_bytes(s);
		// end flag inside the header
		s.delete();
		s.push_back(MAGIC_WORD[7:0]);
		s.push_back(MAGIC_WORD[15:8]);
		queue_bytes(s);
		while (pending_bytes.size() < BYTE_TARGET) add_random_stream();

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		do @(negedge clk);
		while (pending_bytes.size() > 0 || in_valid || expected_words.size() > 0);
		repeat (20) @(negedge clk);
		if (expected_words.size() > 0) begin
			$error("%0d expected words never arrived", expected_words.size());
			mismatches++;
		end
		$display("%0d bytes in %0d streams decoded, %0d words checked", bytes_in, streams_in,
			words_out);
		$display("status words: ok %0d, bad magic %0d, size mismatch %0d, truncated %0d",
			status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
		if (mismatches == 0) begin
			$display("run_length_packet_decoder_unit verification clean");
		end else begin
			$display("run_length_packet_decoder_unit verification failed");
		end
		$finish;
	end

endmodule
